// ----- rtl/psu_setpoint_link_sequencer_top_defines.svh -----
// Assertion helpers shared by the sequencer RTL. Each use expands to one
// labelled concurrent assertion on the block clock, masked while in reset.
`ifndef PSU_SETPOINT_LINK_SEQUENCER_TOP_DEFINES_SVH
`define PSU_SETPOINT_LINK_SEQUENCER_TOP_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PSU_SEQ_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PSU_SEQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/psu_seq_pkg.sv -----
package psu_seq_pkg;

    localparam int FRACTION_BITS_DEF = 16;
    localparam int CFG_W             = 32;
    localparam int CFG_IDX_W         = 3;
    localparam int DIGIT_W           = 8;
    localparam int SCALE_W           = 10;
    localparam int BYTE_W            = 8;

    localparam logic [SCALE_W-1:0] MASK_CHECK  = 10'h3C0;
    localparam logic [SCALE_W-1:0] MASK_LOW    = 10'h007;
    localparam logic [SCALE_W-1:0] MASK_HIGH   = 10'h3F8;
    localparam logic [SCALE_W-1:0] MARK_SECOND = 10'h001;

    typedef enum logic [1:0] {
        OP_TICK = 2'd0,
        OP_STOP = 2'd1,
        OP_WAIT = 2'd2,
        OP_TRIG = 2'd3
    } t_opcode;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CURRENT_STEP = 3'd0,
        CFG_ZERO_POINT   = 3'd1,
        CFG_SCALE_MIN    = 3'd2,
        CFG_SCALE_MAX    = 3'd3,
        CFG_START_FIRST  = 3'd4,
        CFG_START_SECOND = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        STG_IDLE      = 4'b0001,
        STG_WAIT      = 4'b0010,
        STG_DISCHARGE = 4'b0100,
        STG_STOP      = 4'b1000
    } t_stage;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_ADD  = 5'b00100,
        S_FIN  = 5'b01000,
        S_PUSH = 5'b10000
    } t_state;

    typedef struct packed {
        t_opcode            opcode;
        logic signed [31:0] current_setpoint;
    } t_in_item;

    typedef struct packed {
        logic [BYTE_W-1:0] first_byte;
        logic [BYTE_W-1:0] second_byte;
    } t_out_item;

    // Packs a scale point into the two link bytes, with the top four bits
    // sent inverted as a check.
    function automatic t_out_item pack_point(input logic [SCALE_W-1:0] pc);
        logic [SCALE_W-1:0] nc;
        logic [SCALE_W-1:0] first_w;
        logic [SCALE_W-1:0] second_w;
        t_out_item          res;
        nc       = ~pc;
        first_w  = ((nc & MASK_CHECK) >> 5) | ((pc & MASK_LOW) << 5);
        second_w = MARK_SECOND | ((pc & MASK_HIGH) >> 2);
        res.first_byte  = first_w[BYTE_W-1:0];
        res.second_byte = second_w[BYTE_W-1:0];
        return res;
    endfunction

endpackage

// ----- rtl/psu_setpoint_link_sequencer_top.sv -----
// Power supply setpoint link sequencer. One beat is taken at a time, only
// while the controller is idle. Commands, and ticks outside the discharge
// stage, update the stage and trigger flag; a tick in the wait stage with
// the trigger set, or in the stop stage, also sends the start/stop message.
// A tick in the discharge stage divides the setpoint by the current step in
// a restoring divider that yields one quotient bit per cycle; the zero point
// is then added one byte per cycle, and the point is saturated, packed and
// passed to the output register. A result that finds the output register
// still holding an unaccepted beat waits until that beat is taken, so output
// stalls lengthen the item. The output register lets a new beat be taken
// while an earlier result waits in it to be accepted.
`include "psu_setpoint_link_sequencer_top_defines.svh"

module psu_setpoint_link_sequencer_top
    import psu_seq_pkg::*;
#(
    parameter int FRACTION_BITS = FRACTION_BITS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_in_item             i_in_data,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_out_item            o_out_data,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    localparam int DW = 32 + FRACTION_BITS;
    localparam int SW = DW + 2;
    localparam int AW = ((SW + DIGIT_W - 1) / DIGIT_W) * DIGIT_W;
    localparam int ND = AW / DIGIT_W;
    localparam int CW = $clog2(DW);

    // Control state.
    t_state               r_state, n_state;
    t_stage               r_stage, n_stage;
    logic                 r_trig, n_trig;
    logic                 r_out_valid, n_out_valid;
    logic [CW-1:0]        r_cnt, n_cnt;

    // Configuration.
    logic [31:0]          r_current_step, n_current_step;
    logic [31:0]          r_zero_point, n_zero_point;
    logic [SCALE_W-1:0]   r_scale_min, n_scale_min;
    logic [SCALE_W-1:0]   r_scale_max, n_scale_max;
    logic [BYTE_W-1:0]    r_start_first, n_start_first;
    logic [BYTE_W-1:0]    r_start_second, n_start_second;

    // Datapath.
    logic [31:0]          r_divisor, n_divisor;
    logic [31:0]          r_rem, n_rem;
    logic [DW-1:0]        r_dvd, n_dvd;
    logic                 r_neg, n_neg;
    logic                 r_carry, n_carry;
    logic [AW-1:0]        r_zp, n_zp;
    logic [AW-1:0]        r_sum, n_sum;
    t_out_item            r_res, n_res;
    t_out_item            r_out, n_out;

    logic                 in_acc;
    logic [31:0]          sp_bits;
    logic [31:0]          sp_abs;
    logic [32:0]          div_trial;
    logic [32:0]          div_diff;
    logic                 div_ge;
    logic [DIGIT_W:0]     add_sum;
    logic                 s_neg;
    logic                 s_big;
    logic [SCALE_W-1:0]   p_low;
    logic [SCALE_W-1:0]   p_floor;
    logic [SCALE_W-1:0]   p_final;

    // Qualifiers for the assertions at the end of the module.
    logic                 chk_tick;
    logic                 chk_div_first;
    logic                 chk_div_last;
    logic                 chk_cnt_ok;
    logic                 chk_push;
    logic                 chk_pushed;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign in_acc      = i_in_valid && o_in_ready;

    assign sp_bits = i_in_data.current_setpoint;
    assign sp_abs  = sp_bits[31] ? (~sp_bits + 32'd1) : sp_bits;

    // One restoring division step: the next dividend bit joins the
    // remainder and the quotient bit shifts in at the bottom.
    assign div_trial = {r_rem, r_dvd[DW-1]};
    assign div_diff  = div_trial - {1'b0, r_divisor};
    assign div_ge    = (div_trial >= {1'b0, r_divisor});

    // A negative quotient is added as its ones' complement with a carry in.
    assign add_sum = {1'b0, r_zp[DIGIT_W-1:0]}
                   + {1'b0, r_dvd[DIGIT_W-1:0] ^ {DIGIT_W{r_neg}}}
                   + {{DIGIT_W{1'b0}}, r_carry};

    // A negative sum truncates to a point at or below zero, which the floor
    // always meets; a sum with bits above the scale range meets the ceiling.
    assign s_neg   = r_sum[AW-1];
    assign s_big   = |r_sum[AW-1:FRACTION_BITS+SCALE_W];
    assign p_low   = r_sum[FRACTION_BITS+SCALE_W-1:FRACTION_BITS];
    assign p_floor = s_neg ? r_scale_min :
                     s_big ? r_scale_max :
                     (p_low < r_scale_min) ? r_scale_min : p_low;
    assign p_final = (p_floor > r_scale_max) ? r_scale_max : p_floor;

    always_comb begin
        n_state        = r_state;
        n_stage        = r_stage;
        n_trig         = r_trig;
        n_cnt          = r_cnt;
        n_out_valid    = r_out_valid && !i_out_ready;
        n_current_step = r_current_step;
        n_zero_point   = r_zero_point;
        n_scale_min    = r_scale_min;
        n_scale_max    = r_scale_max;
        n_start_first  = r_start_first;
        n_start_second = r_start_second;
        n_divisor      = r_divisor;
        n_rem          = r_rem;
        n_dvd          = r_dvd;
        n_neg          = r_neg;
        n_carry        = r_carry;
        n_zp           = r_zp;
        n_sum          = r_sum;
        n_res          = r_res;
        n_out          = r_out;

        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CURRENT_STEP: n_current_step = i_cfg_data;
                CFG_ZERO_POINT:   n_zero_point   = i_cfg_data;
                CFG_SCALE_MIN:    n_scale_min    = i_cfg_data[SCALE_W-1:0];
                CFG_SCALE_MAX:    n_scale_max    = i_cfg_data[SCALE_W-1:0];
                CFG_START_FIRST:  n_start_first  = i_cfg_data[BYTE_W-1:0];
                CFG_START_SECOND: n_start_second = i_cfg_data[BYTE_W-1:0];
                default:          ;
            endcase
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in_data.opcode)
                        OP_STOP: n_stage = STG_STOP;
                        OP_WAIT: n_stage = STG_WAIT;
                        OP_TRIG: n_trig  = 1'b1;
                        OP_TICK: begin
                            case (r_stage)
                                STG_IDLE: n_trig = 1'b0;
                                STG_WAIT: begin
                                    if (r_trig) begin
                                        n_res.first_byte  = r_start_first;
                                        n_res.second_byte = r_start_second;
                                        n_stage           = STG_DISCHARGE;
                                        n_state           = S_PUSH;
                                    end
                                end
                                STG_DISCHARGE: begin
                                    n_divisor = (r_current_step == 32'd0) ? 32'd1
                                                                          : r_current_step;
                                    n_rem     = 32'd0;
                                    n_dvd     = {sp_abs, {FRACTION_BITS{1'b0}}};
                                    n_neg     = sp_bits[31];
                                    n_carry   = sp_bits[31];
                                    n_zp      = {{(AW-32){r_zero_point[31]}}, r_zero_point};
                                    n_cnt     = '0;
                                    n_state   = S_DIV;
                                end
                                STG_STOP: begin
                                    n_res.first_byte  = r_start_first;
                                    n_res.second_byte = r_start_second;
                                    n_stage           = STG_IDLE;
                                    n_state           = S_PUSH;
                                end
                                default: n_stage = STG_IDLE;
                            endcase
                        end
                        default: ;
                    endcase
                end
            end
            S_DIV: begin
                n_rem = div_ge ? div_diff[31:0] : div_trial[31:0];
                n_dvd = {r_dvd[DW-2:0], div_ge};
                if (r_cnt == CW'(DW - 1)) begin
                    n_cnt   = '0;
                    n_state = S_ADD;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_ADD: begin
                n_sum   = {add_sum[DIGIT_W-1:0], r_sum[AW-1:DIGIT_W]};
                n_carry = add_sum[DIGIT_W];
                n_zp    = r_zp >> DIGIT_W;
                n_dvd   = r_dvd >> DIGIT_W;
                if (r_cnt == CW'(ND - 1)) begin
                    n_cnt   = '0;
                    n_state = S_FIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_FIN: begin
                n_res   = pack_point(p_final);
                n_state = S_PUSH;
            end
            S_PUSH: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_stage        <= STG_IDLE;
            r_trig         <= 1'b0;
            r_cnt          <= '0;
            r_out_valid    <= 1'b0;
            r_current_step <= 32'd65536;
            r_zero_point   <= 32'd0;
            r_scale_min    <= '0;
            r_scale_max    <= '1;
            r_start_first  <= '0;
            r_start_second <= '0;
        end else begin
            r_state        <= n_state;
            r_stage        <= n_stage;
            r_trig         <= n_trig;
            r_cnt          <= n_cnt;
            r_out_valid    <= n_out_valid;
            r_current_step <= n_current_step;
            r_zero_point   <= n_zero_point;
            r_scale_min    <= n_scale_min;
            r_scale_max    <= n_scale_max;
            r_start_first  <= n_start_first;
            r_start_second <= n_start_second;
        end
    end

    always_ff @(posedge i_clk) begin
        r_divisor <= n_divisor;
        r_rem     <= n_rem;
        r_dvd     <= n_dvd;
        r_neg     <= n_neg;
        r_carry   <= n_carry;
        r_zp      <= n_zp;
        r_sum     <= n_sum;
        r_res     <= n_res;
        r_out     <= n_out;
    end

    assign chk_tick      = in_acc && (i_in_data.opcode == OP_TICK)
                           && (r_stage == STG_DISCHARGE);
    assign chk_div_first = (r_state == S_DIV) && (r_cnt == '0);
    assign chk_div_last  = (r_state == S_DIV) && (r_cnt == CW'(DW - 1));
    assign chk_cnt_ok    = (r_cnt <= CW'(DW - 1));
    assign chk_push      = (r_state == S_PUSH) && (!r_out_valid || i_out_ready);
    assign chk_pushed    = o_out_valid && (r_state == S_IDLE);

    `PSU_SEQ_ASSERT_NEXT(a_tick_starts_div, chk_tick, chk_div_first, "divider not started")
    `PSU_SEQ_ASSERT_SAME(a_div_count_range, r_state == S_DIV, chk_cnt_ok, "bad divider count")
    `PSU_SEQ_ASSERT_NEXT(a_div_to_add, chk_div_last, r_state == S_ADD, "adder not started")
    `PSU_SEQ_ASSERT_NEXT(a_point_marked, r_state == S_FIN, r_res.second_byte[0], "no mark bit")
    `PSU_SEQ_ASSERT_NEXT(a_push_delivers, chk_push, chk_pushed, "result not moved out")

endmodule
